>>> rtl/srg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srg_pkg;

  localparam int MAX_AXES     = 8;
  localparam int AXES_DEFAULT = 3;
  localparam int ES_AXES      = 3;   // axes that have an endstop input

  localparam int POS_W      = 32;
  localparam int SPEED_W    = 9;
  localparam int MIN_SPEED  = 10;
  localparam int RAMP_STEPS = 1024;  // power of two
  localparam int ACCU_WRAP  = 256;   // power of two
  localparam int RAMP_SH    = $clog2(RAMP_STEPS);
  localparam int RAMP_W     = RAMP_SH + 1;
  localparam int ACCU_SH    = $clog2(ACCU_WRAP);
  localparam int CNT_W      = SPEED_W + 1 - ACCU_SH;

  localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = SPEED_W'(400);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_MAX_SPEED = 1'b0,
    CFG_RESPECT   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] target;
    logic signed [POS_W-1:0] start;
    logic [RAMP_W-1:0]       ramp;
    logic [ACCU_SH-1:0]      phase;
  } axis_state_t;

  typedef struct packed {
    opcode_t op;
    logic    hit;
    logic    blocked;
  } axis_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/three_axis_stepper_ramp_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Stepper pulse generator with a trapezoidal speed profile for AXES axes.
// Each item is either a tick (move all axes by their phase accumulators, honouring
// endstops in axis order) or a new absolute target for every axis. One item is taken
// per clock while in_stall is low, and its result is offered once it has passed
// two registers: the item is held in an input register, then one pass of per-axis
// logic (one 10x12 multiplier, a 33-bit subtract and compare per axis) updates the
// axis state, which is also the result register. While a result waits on out_stall
// one further item is still taken into the input register.
module three_axis_stepper_ramp_generator #(
  parameter int AXES = srg_pkg::AXES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [srg_pkg::SPEED_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [2:0]                        endstop_bits,
  input  logic signed [srg_pkg::POS_W-1:0]  target_half_steps,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        step_levels,
  output logic [2:0]                        dir_levels,
  output logic [2:0]                        moving_flags,
  output logic                              endstop_stopped,
  output logic signed [srg_pkg::POS_W-1:0]  pos_x,
  output logic signed [srg_pkg::POS_W-1:0]  pos_y,
  output logic signed [srg_pkg::POS_W-1:0]  pos_z
);
  import srg_pkg::*;

  logic [SPEED_W-1:0]      max_speed;
  logic                    respect;

  logic                    in_full;
  opcode_t                 op_r;
  logic [2:0]              es_r;
  logic signed [POS_W-1:0] t_r;
  logic                    advance;

  axis_state_t             st      [AXES];
  axis_state_t             st_next [AXES];
  logic [AXES-1:0]         step_pin, dir_pin, moving;
  logic [AXES-1:0]         step_pin_next, dir_pin_next, moving_next;
  logic [AXES-1:0]         hit, blocked, toggle, dir_set;
  logic                    stopped;

  logic [MAX_AXES-1:0]     step_ext, dir_ext, moving_ext;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= MAX_SPEED_RESET;
      respect   <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_MAX_SPEED: max_speed <= cfg_data;
        CFG_RESPECT:   respect   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r <= opcode_t'(opcode);
      es_r <= endstop_bits;
      t_r  <= target_half_steps;
    end
  end

  genvar a;
  generate
    for (a = 0; a < AXES; a++) begin : g_axis
      axis_ctrl_t ctrl;

      if (a < ES_AXES) begin : g_es
        assign hit[a] = respect && es_r[a];
      end else begin : g_no_es
        assign hit[a] = 1'b0;
      end

      if (a == 0) begin : g_first
        assign blocked[a] = 1'b0;
      end else begin : g_rest
        assign blocked[a] = blocked[a-1] || hit[a-1];
      end

      assign ctrl.op      = op_r;
      assign ctrl.hit     = hit[a];
      assign ctrl.blocked = blocked[a];

      srg_axis u_axis (
        .ctrl      (ctrl),
        .target_in (t_r),
        .max_speed (max_speed),
        .cur       (st[a]),
        .nxt       (st_next[a]),
        .dir_set   (dir_set[a]),
        .toggle    (toggle[a])
      );

      assign moving_next[a] = st_next[a].target != st_next[a].position;
    end
  endgenerate

  assign step_pin_next = step_pin ^ toggle;
  assign dir_pin_next  = (op_r == OP_SET) ? dir_set : dir_pin;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        st[i] <= '0;
      end
      step_pin  <= '0;
      dir_pin   <= '0;
      moving    <= '0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        for (int i = 0; i < AXES; i++) begin
          st[i] <= st_next[i];
        end
        step_pin  <= step_pin_next;
        dir_pin   <= dir_pin_next;
        moving    <= moving_next;
        stopped   <= (op_r == OP_TICK) && (|hit);
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign step_ext   = MAX_AXES'(step_pin);
  assign dir_ext    = MAX_AXES'(dir_pin);
  assign moving_ext = MAX_AXES'(moving);

  assign step_levels     = step_ext[2:0];
  assign dir_levels      = dir_ext[2:0];
  assign moving_flags    = moving_ext[2:0];
  assign endstop_stopped = stopped;
  assign pos_x           = st[0].position;

  generate
    if (AXES > 1) begin : g_pos_y
      assign pos_y = st[1].position;
    end else begin : g_no_pos_y
      assign pos_y = '0;
    end
    if (AXES > 2) begin : g_pos_z
      assign pos_z = st[2].position;
    end else begin : g_no_pos_z
      assign pos_z = '0;
    end
  endgenerate

  // input side only holds off when the input register is full and the result slot is full and stalled
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && in_full))
    else $error("input stalled with a free result slot");

  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_full))
    else $error("result raised without a held item");

  // every half-step flips both the step pin and the position parity
  generate
    for (a = 0; a < AXES; a++) begin : g_chk
      a_step_parity: assert property (@(posedge clk) disable iff (rst)
        step_pin[a] == st[a].position[0])
        else $error("step pin out of step with position");
    end
  endgenerate

endmodule

`default_nettype wire

>>> rtl/srg_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module srg_axis (
  input  srg_pkg::axis_ctrl_t              ctrl,
  input  logic signed [srg_pkg::POS_W-1:0] target_in,
  input  logic [srg_pkg::SPEED_W-1:0]      max_speed,
  input  srg_pkg::axis_state_t             cur,
  output srg_pkg::axis_state_t             nxt,
  output logic                             dir_set,
  output logic                             toggle
);
  import srg_pkg::*;

  localparam int PROD_W = SPEED_W + 1 + RAMP_W + 1;
  localparam logic [PROD_W-1:0] RND = PROD_W'(RAMP_STEPS - 1);

  logic [POS_W:0]           remain, dist_abs, from_src, from_abs, diff_set, diff_abs;
  logic [POS_W-1:0]         half;
  logic [RAMP_W-1:0]        ramp_set, ramp_d;
  logic                     near_end, near_start, positive;
  logic signed [SPEED_W:0]  span;
  logic signed [PROD_W-1:0] prod, prod_adj, q;
  logic [PROD_W-1:0]        speed_s;
  logic [SPEED_W-1:0]       ramp_spd, speed;
  logic [SPEED_W:0]         accu;
  logic [CNT_W-1:0]         ovf, steps;
  logic [POS_W-1:0]         step_ext, pos_mv;

  // new target
  assign diff_set = {target_in[POS_W-1], target_in} - {cur.position[POS_W-1], cur.position};
  assign diff_abs = diff_set[POS_W] ? -diff_set : diff_set;
  assign half     = diff_abs[POS_W:1];
  assign ramp_set = (half < POS_W'(RAMP_STEPS)) ? half[RAMP_W-1:0] : RAMP_W'(RAMP_STEPS);
  assign dir_set  = target_in > cur.position;

  // ramp profile
  assign remain     = {cur.target[POS_W-1], cur.target} - {cur.position[POS_W-1], cur.position};
  assign dist_abs   = remain[POS_W] ? -remain : remain;
  assign positive   = !remain[POS_W];
  assign from_src   = {cur.position[POS_W-1], cur.position} - {cur.start[POS_W-1], cur.start};
  assign from_abs   = from_src[POS_W] ? -from_src : from_src;
  assign near_end   = dist_abs < (POS_W+1)'(cur.ramp);
  assign near_start = from_abs < (POS_W+1)'(cur.ramp);
  assign ramp_d     = near_end ? dist_abs[RAMP_W-1:0] : from_abs[RAMP_W-1:0];

  assign span     = $signed({1'b0, max_speed}) - $signed((SPEED_W+1)'(MIN_SPEED));
  assign prod     = span * $signed({1'b0, ramp_d});
  // divide rounding toward zero
  assign prod_adj = prod + (prod[PROD_W-1] ? $signed(RND) : $signed(PROD_W'(0)));
  assign q        = prod_adj >>> RAMP_SH;
  assign speed_s  = q + PROD_W'(MIN_SPEED);
  assign ramp_spd = speed_s[PROD_W-1] ? '0 : speed_s[SPEED_W-1:0];
  assign speed    = (near_end || near_start) ? ramp_spd : max_speed;

  // phase accumulator, never step past the target
  assign accu     = (SPEED_W+1)'(cur.phase) + (SPEED_W+1)'(speed);
  assign ovf      = accu[SPEED_W:ACCU_SH];
  assign steps    = (dist_abs < (POS_W+1)'(ovf)) ? dist_abs[CNT_W-1:0] : ovf;
  assign step_ext = POS_W'(steps);
  assign pos_mv   = positive ? cur.position + step_ext : cur.position - step_ext;

  always_comb begin
    nxt    = cur;
    toggle = 1'b0;
    case (ctrl.op)
      OP_SET: begin
        nxt.start  = cur.position;
        nxt.target = target_in;
        nxt.ramp   = ramp_set;
      end
      OP_TICK: begin
        if (!ctrl.blocked) begin
          if (ctrl.hit) begin
            nxt.target = cur.position;
          end else if (remain != '0) begin
            nxt.position = pos_mv;
            nxt.phase    = accu[ACCU_SH-1:0];
            toggle       = steps[0];
          end
        end
      end
      default: nxt = cur;
    endcase
  end

endmodule

`default_nettype wire
